// ===== design/dsrm_pkg.sv =====
`default_nettype none

package dsrm_pkg;

  // shared divider widths
  localparam int DIV_NW = 26;                     // dividend and quotient
  localparam int DIV_DW = 17;                     // divisor and remainder
  localparam int DIV_CW = $clog2(DIV_NW + 1);     // iteration count

  // configuration port
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 16;

  localparam logic [CFG_IW-1:0] REG_MAX_SPEED  = 2'd0;
  localparam logic [CFG_IW-1:0] REG_MINUTE_REV = 2'd1;
  localparam logic [CFG_IW-1:0] REG_HOUR_REV   = 2'd2;

  localparam logic [9:0]  MAX_SPEED_RST  = 10'd15;
  localparam logic [15:0] MINUTE_REV_RST = 16'd16000;
  localparam logic [15:0] HOUR_REV_RST   = 16'd12000;

  // default build options
  localparam int HOUR_DIVIDER_DEF = 12;
  localparam int RAMP_DIVISOR_DEF = 15;

  // pulse gap
  localparam logic [9:0] GAP_NUM = 10'd1000;
  localparam logic [9:0] GAP_MIN = 10'd10;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
    logic [DIV_CW-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
    logic [DIV_DW-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== design/dsrm_div.sv =====
`default_nettype none

module dsrm_div (
  input  logic               clk,
  input  logic               rst_n,
  input  dsrm_pkg::div_req_t req,
  output dsrm_pkg::div_rsp_t rsp
);
  import dsrm_pkg::*;

  logic [DIV_NW-1:0] quot_r, quot_nxt;
  logic [DIV_DW-1:0] rem_r, rem_nxt;
  logic [DIV_DW-1:0] dvs_r, dvs_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [DIV_DW:0]   trial;
  logic [DIV_DW:0]   diff;
  logic              ge;

  // restoring division, one quotient bit a cycle
  always_comb begin
    trial    = {rem_r, quot_r[DIV_NW-1]};
    diff     = trial - {1'b0, dvs_r};
    ge       = (trial >= {1'b0, dvs_r});
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (req.start) begin
      // left-align the dividend so only nbits iterations are needed
      quot_nxt = req.dividend << (DIV_CW'(DIV_NW) - req.nbits);
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = req.nbits;
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
      quot_nxt = {quot_r[DIV_NW-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == DIV_CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

// ===== design/dual_stepper_ramped_move_core.sv =====
`default_nettype none

// path from input transfer to out_valid: an idle tick goes straight to the output stage, a start
// runs the ramp division (16 bits), and a tick during a move runs its divisions on the shared divider:
// speed 26 bits (ramps only), gap 10 bits, 17 bits per pulsing motor, then the result is registered
// throughput: one item at a time, in_ready returns on the edge that registers the result
// the single restoring divider (one quotient bit a cycle) serves every division in turn
// reset (synchronous, rst_n low): idle, no move, positions 0, registers at defaults
module dual_stepper_ramped_move_core #(
  parameter int HOUR_DIVIDER = dsrm_pkg::HOUR_DIVIDER_DEF,
  parameter int RAMP_DIVISOR = dsrm_pkg::RAMP_DIVISOR_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration writes
  input  logic                        cfg_we,
  input  logic [dsrm_pkg::CFG_IW-1:0] cfg_index,
  input  logic [dsrm_pkg::CFG_DW-1:0] cfg_data,
  // command channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_cmd,
  input  logic [15:0]                 in_minute_steps,
  input  logic [15:0]                 in_hour_steps,
  input  logic                        in_clockwise,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_pulse_minute,
  output logic                        out_pulse_hour,
  output logic [9:0]                  out_step_speed,
  output logic [9:0]                  out_gap_us,
  output logic [15:0]                 out_minute_position,
  output logic [15:0]                 out_hour_position,
  output logic                        out_move_done,
  output logic                        out_busy_res
);
  import dsrm_pkg::*;

  localparam int RES_W = (HOUR_DIVIDER > 1) ? $clog2(HOUR_DIVIDER) : 1;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_KICK = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  // divider jobs
  localparam logic [2:0] OP_RAMP  = 3'd0;
  localparam logic [2:0] OP_SPEED = 3'd1;
  localparam logic [2:0] OP_GAP   = 3'd2;
  localparam logic [2:0] OP_MPOS  = 3'd3;
  localparam logic [2:0] OP_HPOS  = 3'd4;

  // iterations per job
  localparam logic [DIV_CW-1:0] N_RAMP  = DIV_CW'(16);
  localparam logic [DIV_CW-1:0] N_SPEED = DIV_CW'(DIV_NW);
  localparam logic [DIV_CW-1:0] N_GAP   = DIV_CW'(10);
  localparam logic [DIV_CW-1:0] N_POS   = DIV_CW'(DIV_DW);

  // configuration registers
  logic [9:0]  max_speed_r;
  logic [15:0] minute_rev_r;
  logic [15:0] hour_rev_r;

  // sequencer
  logic [2:0] state_r;
  logic [2:0] op_r;

  // move state
  logic             active_r;
  logic [15:0]      step_r;
  logic [15:0]      total_r;
  logic [15:0]      ramp_r;
  logic [15:0]      mgoal_r;
  logic [15:0]      hgoal_r;
  logic [15:0]      mdone_r;
  logic [15:0]      hdone_r;
  logic [RES_W-1:0] mres_r;      // minute count modulo the hour divider
  logic             cw_r;
  logic [15:0]      mpos_r;
  logic [15:0]      hpos_r;

  // result being built
  logic              pm_r;
  logic              ph_r;
  logic [9:0]        speed_r;
  logic [9:0]        gap_r;
  logic              fin_r;
  logic              busy_r;
  logic              up_r;
  logic [DIV_NW-1:0] prod_r;

  // output register
  logic        out_valid_r;
  logic        out_pm_r;
  logic        out_ph_r;
  logic [9:0]  out_speed_r;
  logic [9:0]  out_gap_r;
  logic [15:0] out_mpos_r;
  logic [15:0] out_hpos_r;
  logic        out_fin_r;
  logic        out_busy_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // helpers
  logic              in_xfer;
  logic              out_free;
  logic [15:0]       in_total;
  logic [9:0]        top;
  logic [9:0]        top_m1;
  logic [16:0]       sum_sr;
  logic [16:0]       down_d;
  logic              in_up;
  logic              in_down;
  logic [15:0]       mul_a;
  logic [DIV_NW-1:0] prod;
  logic              pm;
  logic              ph;
  logic [RES_W-1:0]  mres_inc;
  logic [RES_W-1:0]  mres_new;
  logic [15:0]       step_inc;
  logic              fin;
  logic [DIV_DW-1:0] mrev;
  logic [DIV_DW-1:0] hrev;
  logic [DIV_DW-1:0] mpos_arg;
  logic [DIV_DW-1:0] hpos_arg;
  logic [9:0]        q10;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign in_total = (in_minute_steps > in_hour_steps) ? in_minute_steps : in_hour_steps;

  // zero peak speed behaves as one
  assign top    = (max_speed_r == '0) ? 10'd1 : max_speed_r;
  assign top_m1 = top - 10'd1;

  // ramp region of the current step
  assign sum_sr  = {1'b0, step_r} + {1'b0, ramp_r};
  assign in_up   = (step_r < ramp_r);
  assign in_down = (sum_sr > {1'b0, total_r});
  assign down_d  = sum_sr - {1'b0, total_r};
  assign mul_a   = in_up ? step_r : down_d[15:0];
  assign prod    = {10'b0, mul_a} * {16'b0, top_m1};

  // pulse decisions, hour follows the minute count after this step
  assign pm       = (mdone_r < mgoal_r);
  assign mres_inc = (mres_r == RES_W'(HOUR_DIVIDER - 1)) ? '0 : mres_r + 1'b1;
  assign mres_new = pm ? mres_inc : mres_r;
  assign ph       = (hdone_r < hgoal_r) && (mres_new == '0);
  assign step_inc = step_r + 16'd1;
  assign fin      = (step_inc >= total_r);

  // a zero revolution length is a plain 16-bit wrap
  assign mrev     = (minute_rev_r == '0) ? 17'h10000 : {1'b0, minute_rev_r};
  assign hrev     = (hour_rev_r == '0) ? 17'h10000 : {1'b0, hour_rev_r};
  assign mpos_arg = cw_r ? {1'b0, mpos_r} + 17'd1 : {1'b0, mpos_r} + mrev - 17'd1;
  assign hpos_arg = cw_r ? {1'b0, hpos_r} + 17'd1 : {1'b0, hpos_r} + hrev - 17'd1;

  assign q10 = div_rsp.quot[9:0];

  // operand select for the shared divider
  always_comb begin
    div_req.start    = (state_r == S_KICK);
    div_req.dividend = DIV_NW'(total_r);
    div_req.divisor  = DIV_DW'(RAMP_DIVISOR);
    div_req.nbits    = N_RAMP;
    case (op_r)
      OP_SPEED: begin
        div_req.dividend = prod_r;
        div_req.divisor  = {1'b0, ramp_r};
        div_req.nbits    = N_SPEED;
      end
      OP_GAP: begin
        div_req.dividend = DIV_NW'(GAP_NUM);
        div_req.divisor  = DIV_DW'(speed_r);
        div_req.nbits    = N_GAP;
      end
      OP_MPOS: begin
        div_req.dividend = DIV_NW'(mpos_arg);
        div_req.divisor  = mrev;
        div_req.nbits    = N_POS;
      end
      OP_HPOS: begin
        div_req.dividend = DIV_NW'(hpos_arg);
        div_req.divisor  = hrev;
        div_req.nbits    = N_POS;
      end
      default: ;
    endcase
  end

  dsrm_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  // sequencer, move state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r  <= MAX_SPEED_RST;
      minute_rev_r <= MINUTE_REV_RST;
      hour_rev_r   <= HOUR_REV_RST;
      state_r      <= S_IDLE;
      op_r         <= OP_RAMP;
      active_r     <= 1'b0;
      step_r       <= '0;
      total_r      <= '0;
      ramp_r       <= '0;
      mgoal_r      <= '0;
      hgoal_r      <= '0;
      mdone_r      <= '0;
      hdone_r      <= '0;
      mres_r       <= '0;
      cw_r         <= 1'b0;
      mpos_r       <= '0;
      hpos_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MAX_SPEED:  max_speed_r  <= cfg_data[9:0];
          REG_MINUTE_REV: minute_rev_r <= cfg_data;
          REG_HOUR_REV:   hour_rev_r   <= cfg_data;
          default: ;
        endcase
      end

      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            if (!in_cmd) begin
              // start aborts any running move, positions are kept
              mgoal_r  <= in_minute_steps;
              hgoal_r  <= in_hour_steps;
              cw_r     <= in_clockwise;
              total_r  <= in_total;
              step_r   <= '0;
              mdone_r  <= '0;
              hdone_r  <= '0;
              mres_r   <= '0;
              active_r <= (in_total != '0);
              op_r     <= OP_RAMP;
              state_r  <= S_KICK;
            end else if (active_r) begin
              state_r <= S_MUL;
            end else begin
              state_r <= S_OUT;
            end
          end
        end
        S_MUL: begin
          // commit the step counters, product for the ramp goes to prod_r
          step_r <= step_inc;
          mres_r <= mres_new;
          if (pm) mdone_r <= mdone_r + 16'd1;
          if (ph) hdone_r <= hdone_r + 16'd1;
          if (fin) active_r <= 1'b0;
          op_r    <= (in_up || in_down) ? OP_SPEED : OP_GAP;
          state_r <= S_KICK;
        end
        S_KICK: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (div_rsp.done) begin
            case (op_r)
              OP_RAMP: begin
                ramp_r  <= div_rsp.quot[15:0];
                state_r <= S_OUT;
              end
              OP_SPEED: begin
                op_r    <= OP_GAP;
                state_r <= S_KICK;
              end
              OP_GAP: begin
                if (pm_r) begin
                  op_r    <= OP_MPOS;
                  state_r <= S_KICK;
                end else if (ph_r) begin
                  op_r    <= OP_HPOS;
                  state_r <= S_KICK;
                end else begin
                  state_r <= S_OUT;
                end
              end
              OP_MPOS: begin
                mpos_r <= div_rsp.rem[15:0];
                if (ph_r) begin
                  op_r    <= OP_HPOS;
                  state_r <= S_KICK;
                end else begin
                  state_r <= S_OUT;
                end
              end
              OP_HPOS: begin
                hpos_r  <= div_rsp.rem[15:0];
                state_r <= S_OUT;
              end
              default: state_r <= S_OUT;
            endcase
          end
        end
        S_OUT: begin
          // wait for the output register to free up
          if (out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result fields and output payload
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          // start and idle tick report a resting step
          pm_r    <= 1'b0;
          ph_r    <= 1'b0;
          speed_r <= 10'd1;
          gap_r   <= GAP_NUM;
          fin_r   <= 1'b0;
          busy_r  <= !in_cmd && (in_total != '0);
        end
      end
      S_MUL: begin
        pm_r    <= pm;
        ph_r    <= ph;
        fin_r   <= fin;
        busy_r  <= !fin;
        up_r    <= in_up;
        prod_r  <= prod;
        speed_r <= top;     // plateau value, ramps overwrite it
      end
      S_WAIT: begin
        if (div_rsp.done) begin
          if (op_r == OP_SPEED) begin
            speed_r <= up_r ? q10 + 10'd1 : top - q10;
          end
          if (op_r == OP_GAP) begin
            gap_r <= (q10 < GAP_MIN) ? GAP_MIN : q10;
          end
        end
      end
      default: ;
    endcase

    if (state_r == S_OUT && out_free) begin
      out_pm_r    <= pm_r;
      out_ph_r    <= ph_r;
      out_speed_r <= speed_r;
      out_gap_r   <= gap_r;
      out_mpos_r  <= mpos_r;
      out_hpos_r  <= hpos_r;
      out_fin_r   <= fin_r;
      out_busy_r  <= busy_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_pulse_minute    = out_pm_r;
  assign out_pulse_hour      = out_ph_r;
  assign out_step_speed      = out_speed_r;
  assign out_gap_us          = out_gap_r;
  assign out_minute_position = out_mpos_r;
  assign out_hour_position   = out_hpos_r;
  assign out_move_done       = out_fin_r;
  assign out_busy_res        = out_busy_r;

  // the final step of a move never reports the move as still running
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fin_r |-> !out_busy_r)
    else $error("move_done with busy_res set");

  // a result outside any move carries no pulses
  a_idle_no_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_busy_r && !out_fin_r |-> !out_pm_r && !out_ph_r)
    else $error("pulse outside a move");

  // gap floor holds on every result
  a_gap_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_gap_r >= GAP_MIN)
    else $error("gap below floor");

  // divider results only arrive while the sequencer waits for them
  a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_WAIT)
    else $error("divider finished outside wait");

  // one item at a time: an input transfer is followed by a busy cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("second transfer right after the first");

endmodule

`default_nettype wire
